### rtl/sktm_pkg.sv
// Shared constants and types for the stable key/tag merge sorter.
// Used by sktm_merge_seq and stable_key_tag_merge_sort; depends on nothing.
package sktm_pkg;

  // Capacity of one set and field widths.
  localparam int MAX_ITEMS = 64;
  localparam int KEY_BITS  = 32;
  localparam int TAG_BITS  = 6;

  // Index into the stores, and a count that can also hold MAX_ITEMS itself.
  localparam int IDX_BITS  = $clog2(MAX_ITEMS);
  localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);

  // Stream data width: key then tag, padded to whole bytes.
  localparam int DATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int PAD_BITS  = DATA_BITS - KEY_BITS - TAG_BITS;

  // One stored item.
  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0]        tag;
  } entry_t;

  // Control from the merge sequencer to the store memories.
  typedef struct packed {
    logic                wr_en;
    logic                wr_mem;
    logic [IDX_BITS-1:0] wr_addr;
    logic                take_second;
    logic [IDX_BITS-1:0] rd_addr_first;
    logic [IDX_BITS-1:0] rd_addr_second;
    logic                src;
  } merge_ctl_t;

endpackage

### rtl/sktm_merge_seq.sv
// Merge pass sequencer with the shared key comparator for the merge sorter.
// Walks bottom-up merge passes between two ping-pong stores; uses sktm_pkg.
module sktm_merge_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sktm_pkg::CNT_BITS-1:0]       n,
  input  logic signed [sktm_pkg::KEY_BITS-1:0] key_first,
  input  logic signed [sktm_pkg::KEY_BITS-1:0] key_second,
  output sktm_pkg::merge_ctl_t                ctl,
  output logic                                done
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_RUN   = 2'd1;
  localparam logic [1:0] C_MERGE = 2'd2;

  logic [1:0] state;
  logic       src;

  // Run bounds and cursors: first run [lo, mid), second run [mid, hi), output k.
  logic [sktm_pkg::CNT_BITS-1:0] width;
  logic [sktm_pkg::CNT_BITS-1:0] lo;
  logic [sktm_pkg::CNT_BITS-1:0] mid;
  logic [sktm_pkg::CNT_BITS-1:0] hi;
  logic [sktm_pkg::CNT_BITS-1:0] i;
  logic [sktm_pkg::CNT_BITS-1:0] j;
  logic [sktm_pkg::CNT_BITS-1:0] k;

  logic [sktm_pkg::CNT_BITS:0]   mid_sum;
  logic [sktm_pkg::CNT_BITS:0]   hi_sum;
  logic [sktm_pkg::CNT_BITS-1:0] mid_c;
  logic [sktm_pkg::CNT_BITS-1:0] hi_c;
  logic [sktm_pkg::CNT_BITS-1:0] i_next;
  logic [sktm_pkg::CNT_BITS-1:0] j_next;
  logic [sktm_pkg::CNT_BITS-1:0] k_inc;
  logic                          take_second;

  // Run bounds clamped to the set size, the comparator and cursor updates.
  // The second run wins only on a strictly smaller key, which keeps the sort stable.
  always_comb begin
    mid_sum     = {1'b0, lo} + {1'b0, width};
    hi_sum      = {1'b0, lo} + {width, 1'b0};
    mid_c       = (mid_sum >= {1'b0, n}) ? n : mid_sum[sktm_pkg::CNT_BITS-1:0];
    hi_c        = (hi_sum >= {1'b0, n}) ? n : hi_sum[sktm_pkg::CNT_BITS-1:0];
    take_second = (j < hi) && ((i >= mid) || (key_second < key_first));
    k_inc       = k + sktm_pkg::CNT_BITS'(1);
    i_next      = i;
    j_next      = j;
    unique case (state)
      C_RUN: begin
        i_next = lo;
        j_next = mid_c;
      end
      C_MERGE: begin
        if (take_second) begin
          j_next = j + sktm_pkg::CNT_BITS'(1);
        end else begin
          i_next = i + sktm_pkg::CNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // Read addresses come from the next cursor values so the registered read data matches i and j.
  always_comb begin
    ctl.wr_en          = (state == C_MERGE);
    ctl.wr_mem         = ~src;
    ctl.wr_addr        = k[sktm_pkg::IDX_BITS-1:0];
    ctl.take_second    = take_second;
    ctl.rd_addr_first  = i_next[sktm_pkg::IDX_BITS-1:0];
    ctl.rd_addr_second = j_next[sktm_pkg::IDX_BITS-1:0];
    ctl.src            = src;
  end

  // Pass and run sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      src   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            width <= sktm_pkg::CNT_BITS'(1);
            lo    <= '0;
            src   <= 1'b0;
            if (n > sktm_pkg::CNT_BITS'(1)) begin
              state <= C_RUN;
            end else begin
              done <= 1'b1;
            end
          end
        end
        C_RUN: begin
          mid   <= mid_c;
          hi    <= hi_c;
          i     <= i_next;
          j     <= j_next;
          k     <= lo;
          state <= C_MERGE;
        end
        C_MERGE: begin
          i <= i_next;
          j <= j_next;
          k <= k_inc;
          if (k_inc == hi) begin
            if (hi == n) begin
              // Pass complete: the destination becomes the next source.
              src <= ~src;
              if ({width, 1'b0} >= {1'b0, n}) begin
                done  <= 1'b1;
                state <= C_IDLE;
              end else begin
                width <= {width[sktm_pkg::CNT_BITS-2:0], 1'b0};
                lo    <= '0;
                state <= C_RUN;
              end
            end else begin
              lo    <= hi;
              state <= C_RUN;
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### rtl/stable_key_tag_merge_sort.sv
// Top level of the stable key/tag merge sorter: loading, ping-pong stores, output.
// Depends on sktm_pkg and sktm_merge_seq.
//
// Channel   Dir  Signals                      Content
// s_*       in   tvalid tready tdata tlast    tdata: key[31:0], tag[37:32]; tlast ends set
// m_*       out  tvalid tready tdata tlast    tdata: sorted_key, sorted_tag; tlast end_of_set
//                tuser                        tuser: overflow
//
// Loading accepts transactions while s_tready is high. After the last one, a start phase,
// then the single comparator runs ceil(log2 n) merge passes, then the sort completes,
// a priming read follows, then one result per cycle while m_tready is high.
// Synchronous reset clears the sequencers; store contents are left as they are.
// The input is not ready while a set is sorted or emitted; a stall on m_tready
// holds the current result in the store read register.
module stable_key_tag_merge_sort (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sktm_pkg::DATA_BITS-1:0] s_tdata,   // key, tag, zero pad
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sktm_pkg::DATA_BITS-1:0] m_tdata,   // sorted_key, sorted_tag, zero pad
  output logic                           m_tlast,
  output logic                           m_tuser    // overflow
);

  localparam logic [2:0] P_LOAD  = 3'd0;
  localparam logic [2:0] P_KICK  = 3'd1;
  localparam logic [2:0] P_SORT  = 3'd2;
  localparam logic [2:0] P_PRIME = 3'd3;
  localparam logic [2:0] P_EMIT  = 3'd4;

  logic [2:0]                    phase;
  logic [sktm_pkg::CNT_BITS-1:0] count;
  logic                          ovf;
  logic [sktm_pkg::IDX_BITS-1:0] out_ptr;
  logic [sktm_pkg::IDX_BITS-1:0] out_ptr_next;

  // Ping-pong stores with two registered read ports each.
  sktm_pkg::entry_t mem0 [sktm_pkg::MAX_ITEMS];
  sktm_pkg::entry_t mem1 [sktm_pkg::MAX_ITEMS];
  sktm_pkg::entry_t rd0_first;
  sktm_pkg::entry_t rd0_second;
  sktm_pkg::entry_t rd1_first;
  sktm_pkg::entry_t rd1_second;

  sktm_pkg::merge_ctl_t ctl;
  logic                 done;

  logic                          in_acc;
  logic                          out_acc;
  logic                          load_wr;
  logic                          out_final;
  sktm_pkg::entry_t              load_entry;
  sktm_pkg::entry_t              sel_first;
  sktm_pkg::entry_t              sel_second;
  sktm_pkg::entry_t              merge_entry;
  logic                          we0;
  logic [sktm_pkg::IDX_BITS-1:0] wa0;
  sktm_pkg::entry_t              wd0;
  logic [sktm_pkg::IDX_BITS-1:0] ra_first;

  // Handshakes and the load write.
  assign s_tready   = (phase == P_LOAD);
  assign m_tvalid   = (phase == P_EMIT);
  assign in_acc     = s_tvalid && s_tready;
  assign out_acc    = m_tvalid && m_tready;
  assign load_wr    = in_acc && (count < sktm_pkg::CNT_BITS'(sktm_pkg::MAX_ITEMS));
  assign load_entry = '{key: s_tdata[sktm_pkg::KEY_BITS-1:0],
                        tag: s_tdata[sktm_pkg::KEY_BITS +: sktm_pkg::TAG_BITS]};

  // Read data from the current source store, and the entry the comparator picks.
  assign sel_first   = ctl.src ? rd1_first : rd0_first;
  assign sel_second  = ctl.src ? rd1_second : rd0_second;
  assign merge_entry = ctl.take_second ? sel_second : sel_first;

  // The first read port serves the merge, or the output pointer while emitting.
  assign out_ptr_next = out_ptr + sktm_pkg::IDX_BITS'(out_acc);
  assign ra_first     = ((phase == P_SORT) || (phase == P_KICK)) ? ctl.rd_addr_first
                                                                 : out_ptr_next;

  // Store 0 takes loads and merge writes; store 1 takes merge writes only.
  assign we0 = load_wr || (ctl.wr_en && !ctl.wr_mem);
  assign wa0 = load_wr ? count[sktm_pkg::IDX_BITS-1:0] : ctl.wr_addr;
  assign wd0 = load_wr ? load_entry : merge_entry;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    rd0_first  <= mem0[ra_first];
    rd0_second <= mem0[ctl.rd_addr_second];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_mem) begin
      mem1[ctl.wr_addr] <= merge_entry;
    end
    rd1_first  <= mem1[ra_first];
    rd1_second <= mem1[ctl.rd_addr_second];
  end

  // Merge pass sequencer with the shared comparator.
  sktm_merge_seq u_merge (
    .clk        (clk),
    .rst        (rst),
    .start      (phase == P_KICK),
    .n          (count),
    .key_first  (sel_first.key),
    .key_second (sel_second.key),
    .ctl        (ctl),
    .done       (done)
  );

  // Output fields come straight from the source store's read register.
  assign out_final = ({1'b0, out_ptr} == (count - sktm_pkg::CNT_BITS'(1)));
  assign m_tdata   = {{sktm_pkg::PAD_BITS{1'b0}}, sel_first.tag, sel_first.key};
  assign m_tlast   = out_final;
  assign m_tuser   = ovf;

  // Phase sequencing: load, start the sort, wait, prime the read, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= P_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      out_ptr <= '0;
    end else begin
      unique case (phase)
        P_LOAD: begin
          if (in_acc) begin
            if (load_wr) begin
              count <= count + sktm_pkg::CNT_BITS'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              phase <= P_KICK;
            end
          end
        end
        P_KICK: phase <= P_SORT;
        P_SORT: begin
          if (done) begin
            phase <= P_PRIME;
          end
        end
        P_PRIME: phase <= P_EMIT;
        P_EMIT: begin
          if (out_acc) begin
            if (out_final) begin
              phase   <= P_LOAD;
              count   <= '0;
              ovf     <= 1'b0;
              out_ptr <= '0;
            end else begin
              out_ptr <= out_ptr_next;
            end
          end
        end
        default: phase <= P_LOAD;
      endcase
    end
  end

  // Input and output never open at the same time.
  a_sides_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is offered");

  // Items are dropped only once the store is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == sktm_pkg::CNT_BITS'(sktm_pkg::MAX_ITEMS)))
    else $error("overflow flagged below capacity");

  // Merge writes happen only while sorting, never over a load or an emit.
  a_merge_in_sort: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (phase == P_SORT))
    else $error("merge write outside the sort phase");

  // The sort finishes only while the top level waits for it.
  a_done_in_sort: assert property (@(posedge clk) disable iff (rst)
    done |-> (phase == P_SORT))
    else $error("sort completion outside the sort phase");

  // Every emitted set holds at least one item.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (count != '0) && $past(phase == P_PRIME))
    else $error("emit started without a primed, non-empty set");

endmodule
